>>> rtl/gaussian_5x5_smoothing_unit_assert.svh
// Assertion macros for the 5x5 Gaussian smoothing unit.
// Included by the top level; needs nothing else.
`ifndef GAUSSIAN_5X5_SMOOTHING_UNIT_ASSERT_SVH
`define GAUSSIAN_5X5_SMOOTHING_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GS5_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GS5_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gs5_pkg.sv
// Shared types and constants of the 5x5 Gaussian smoothing unit.
// No dependencies; used by gs5_conv and the top level.
package gs5_pkg;

  // Geometry of the filter window and the line stores.
  localparam int KSIZE  = 5;
  localparam int NLINES = 4;
  localparam int PIX_W  = 8;

  // Field widths of the registers and the result.
  localparam int LINE_WIDTH_W   = 12;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CX_W           = 11;
  localparam int CY_W           = 12;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  // Default parameter values and register reset values.
  localparam int MAX_WIDTH_DEF    = 2048;
  localparam int MAX_HEIGHT_DEF   = 4096;
  localparam int DIVISOR_DEF      = 330;
  localparam int LINE_WIDTH_RST   = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // Mask weights, one per class of symmetric positions.
  localparam int W_CORNER = 1;
  localparam int W_EDGE   = 4;
  localparam int W_MIDRIM = 7;
  localparam int W_INDIAG = 20;
  localparam int W_INAXIS = 33;
  localparam int W_CENTER = 54;

  // Group sums hold up to eight pixels; the weighted sum reaches 330 * 255.
  localparam int GSUM_W = 11;
  localparam int ACC_W  = 17;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // Result queue and pipeline depth of the convolution unit.
  localparam int OUT_FIFO_DEPTH = 8;
  localparam int CONV_STAGES    = 4;

  // Register map.
  typedef enum logic [0:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic [CX_W-1:0]  center_x;
    logic [CY_W-1:0]  center_y;
    logic             frame_last;
  } out_item_t;

  // Position data that travels with a window through the pipeline.
  typedef struct packed {
    logic [CX_W-1:0] center_x;
    logic [CY_W-1:0] center_y;
    logic            frame_last;
  } meta_t;

  // Window[row][col]: row 0 is the oldest row, col 0 the oldest column.
  typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] window_t;

endpackage

>>> rtl/gs5_conv.sv
// Convolution pipeline: mask weighting, division by a constant, saturation.
// Depends on gs5_pkg.
module gs5_conv
  import gs5_pkg::*;
#(
  parameter int DIVISOR = DIVISOR_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   win_valid,
  input  window_t                win,
  input  meta_t                  win_meta,
  output logic                   res_valid,
  output out_item_t              res,
  output logic [CONV_STAGES-1:0] busy
);

  // Division by multiplication with a rounded-up reciprocal; exact for ACC_W-bit sums.
  localparam int              SHIFT    = ACC_W + $clog2(DIVISOR);
  localparam int              RECIP_W  = SHIFT + 1;
  localparam longint unsigned RECIP_L  = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int              PROD_W   = ACC_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic [GSUM_W-1:0] g_corner_r, g_edge_r, g_midrim_r, g_indiag_r, g_inaxis_r, g_center_r;
  logic [ACC_W-1:0]  acc_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  quo;
  meta_t             meta_a_r, meta_b_r, meta_c_r;
  logic              va_r, vb_r, vc_r, vd_r;

  // Valid flags of the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= win_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  // Stage A: sum the pixels that share a mask weight.
  always_ff @(posedge clk) begin
    g_corner_r <= GSUM_W'(win[0][0]) + GSUM_W'(win[0][4])
                + GSUM_W'(win[4][0]) + GSUM_W'(win[4][4]);
    g_edge_r   <= GSUM_W'(win[0][1]) + GSUM_W'(win[0][3])
                + GSUM_W'(win[1][0]) + GSUM_W'(win[1][4])
                + GSUM_W'(win[3][0]) + GSUM_W'(win[3][4])
                + GSUM_W'(win[4][1]) + GSUM_W'(win[4][3]);
    g_midrim_r <= GSUM_W'(win[0][2]) + GSUM_W'(win[2][0])
                + GSUM_W'(win[2][4]) + GSUM_W'(win[4][2]);
    g_indiag_r <= GSUM_W'(win[1][1]) + GSUM_W'(win[1][3])
                + GSUM_W'(win[3][1]) + GSUM_W'(win[3][3]);
    g_inaxis_r <= GSUM_W'(win[1][2]) + GSUM_W'(win[2][1])
                + GSUM_W'(win[2][3]) + GSUM_W'(win[3][2]);
    g_center_r <= GSUM_W'(win[2][2]);
    meta_a_r   <= win_meta;
  end

  // Stage B: weight the group sums by constants and add them up.
  always_ff @(posedge clk) begin
    acc_r <= ACC_W'(g_corner_r) * ACC_W'(W_CORNER)
           + ACC_W'(g_edge_r)   * ACC_W'(W_EDGE)
           + ACC_W'(g_midrim_r) * ACC_W'(W_MIDRIM)
           + ACC_W'(g_indiag_r) * ACC_W'(W_INDIAG)
           + ACC_W'(g_inaxis_r) * ACC_W'(W_INAXIS)
           + ACC_W'(g_center_r) * ACC_W'(W_CENTER);
    meta_b_r <= meta_a_r;
  end

  // Stage C: multiply by the reciprocal of the divisor.
  always_ff @(posedge clk) begin
    prod_r   <= PROD_W'(acc_r) * PROD_W'(RECIP);
    meta_c_r <= meta_b_r;
  end

  // Stage D: take the quotient and saturate it into the result register.
  assign quo = prod_r[SHIFT +: ACC_W];

  always_ff @(posedge clk) begin
    res.smoothed   <= (quo > ACC_W'(PIX_MAX)) ? PIX_MAX : quo[PIX_W-1:0];
    res.center_x   <= meta_c_r.center_x;
    res.center_y   <= meta_c_r.center_y;
    res.frame_last <= meta_c_r.frame_last;
  end

  assign res_valid = vd_r;
  assign busy      = {vd_r, vc_r, vb_r, va_r};

endmodule

>>> rtl/gaussian_5x5_smoothing_unit.sv
// Top level of the 5x5 Gaussian smoothing unit: registers, counters, line store, window, result queue.
// Depends on gs5_pkg, gs5_conv and gaussian_5x5_smoothing_unit_assert.svh.
//
//   port group   direction   handshake                  payload
//   in_          input       in_valid / in_ready        in_item_t (pixel, frame_start)
//   out_         output      out_valid / out_ready      out_item_t (smoothed, center, last)
//   cfg_         input       APB write, pready tied 1   line_width, frame_height
//
// One pixel is accepted per clock while in_ready is high; results are queued after the convolution.
// The line store is one memory of MAX_WIDTH words holding all four rows of a column, read once
// and written once per pixel; a same-column read in the cycle of a write is forwarded.
// in_ready drops when queued plus in-flight results reach the eight-entry result queue.
// Reset is synchronous; the line store is not cleared, no result uses an unwritten entry.
`include "gaussian_5x5_smoothing_unit_assert.svh"

module gaussian_5x5_smoothing_unit
  import gs5_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int DIVISOR    = DIVISOR_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WW     = (LINE_WIDTH_W > AW + 1) ? LINE_WIDTH_W : AW + 1;
  localparam int HW     = (FRAME_HEIGHT_W > ROW_W + 1) ? FRAME_HEIGHT_W : ROW_W + 1;
  localparam int WORD_W = NLINES * PIX_W;
  localparam int DEPTH  = OUT_FIFO_DEPTH;
  localparam int FA     = $clog2(DEPTH);
  localparam int OCC_W  = FA + 2;

  // Configuration registers.
  logic [LINE_WIDTH_W-1:0]   line_width_r;
  logic [FRAME_HEIGHT_W-1:0] frame_height_r;
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_W'(LINE_WIDTH_RST);
      frame_height_r <= FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LINE_WIDTH:   line_width_r   <= cfg_pwdata[LINE_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LINE_WIDTH:   cfg_prdata = CFG_DATA_W'(line_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_W'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Effective frame size, held inside the supported range.
  logic [WW-1:0] lw_e, w;
  logic [HW-1:0] fh_e, h;

  assign lw_e = WW'(line_width_r);
  assign fh_e = HW'(frame_height_r);
  assign w = (lw_e < WW'(KSIZE)) ? WW'(KSIZE) : ((lw_e > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : lw_e);
  assign h = (fh_e < HW'(KSIZE)) ? HW'(KSIZE) :
             ((fh_e > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : fh_e);

  // Position counters: place the incoming pixel, then step past it.
  logic [AW-1:0]    col_r, col_nxt, x;
  logic [ROW_W-1:0] row_r, row_nxt, y;
  logic [WW-1:0]    c0, xn, cx_full;
  logic [HW-1:0]    r0, r1, yn, cy_full;
  logic             in_acc, emit;
  meta_t            meta;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    c0 = in_data.frame_start ? '0 : WW'(col_r);
    r0 = in_data.frame_start ? '0 : HW'(row_r);
    if (c0 >= w) begin
      x  = '0;
      r1 = r0 + HW'(1);
    end else begin
      x  = c0[AW-1:0];
      r1 = r0;
    end
    y = (r1 >= h) ? '0 : r1[ROW_W-1:0];

    xn = WW'(x) + WW'(1);
    yn = HW'(y) + HW'(1);
    if (xn >= w) begin
      col_nxt = '0;
      row_nxt = (yn >= h) ? '0 : yn[ROW_W-1:0];
    end else begin
      col_nxt = xn[AW-1:0];
      row_nxt = y;
    end

    emit            = (WW'(x) >= WW'(KSIZE - 1)) && (HW'(y) >= HW'(KSIZE - 1));
    cx_full         = WW'(x) - WW'(KSIZE / 2);
    cy_full         = HW'(y) - HW'(KSIZE / 2);
    meta.center_x   = cx_full[CX_W-1:0];
    meta.center_y   = cy_full[CY_W-1:0];
    meta.frame_last = (WW'(x) == w - WW'(1)) && (HW'(y) == h - HW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Read stage: the item is registered while the line store word of its column is read.
  logic              s1_v_r, s1_emit_r, fwd_v_r;
  logic [AW-1:0]     s1_x_r;
  logic [PIX_W-1:0]  s1_px_r;
  meta_t             s1_meta_r;
  logic [WORD_W-1:0] rd_data_r, fwd_data_r, old_word, wr_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_emit_r <= 1'b0;
      fwd_v_r   <= 1'b0;
    end else begin
      s1_v_r    <= in_acc;
      s1_emit_r <= in_acc && emit;
      fwd_v_r   <= in_acc && s1_v_r && (s1_x_r == x);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r    <= x;
      s1_px_r   <= in_data.pixel;
      s1_meta_r <= meta;
    end
    fwd_data_r <= wr_word;
  end

  // Line store: four rows of one column per word, row 0 (oldest) in the low byte.
  logic [WORD_W-1:0] line_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= line_mem[x];
    end
    if (s1_v_r) begin
      line_mem[s1_x_r] <= wr_word;
    end
  end

  // A write to the same column in the cycle of the read is taken from the forward register.
  assign old_word = fwd_v_r ? fwd_data_r : rd_data_r;
  assign wr_word  = {s1_px_r, old_word[WORD_W-1:PIX_W]};

  // Window: shift every row left by one and bring in the new column.
  window_t win_r;
  logic    conv_v_r;
  meta_t   conv_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      conv_v_r <= 1'b0;
    end else begin
      conv_v_r <= s1_v_r && s1_emit_r;
      if (s1_v_r) begin
        for (int r = 0; r < KSIZE; r++) begin
          for (int c = 0; c < KSIZE - 1; c++) begin
            win_r[r][c] <= win_r[r][c+1];
          end
        end
        for (int r = 0; r < NLINES; r++) begin
          win_r[r][KSIZE-1] <= old_word[r*PIX_W +: PIX_W];
        end
        win_r[NLINES][KSIZE-1] <= s1_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    conv_meta_r <= s1_meta_r;
  end

  // Convolution pipeline.
  logic                   res_v;
  out_item_t              res;
  logic [CONV_STAGES-1:0] conv_busy;

  gs5_conv #(
    .DIVISOR (DIVISOR)
  ) u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_valid (conv_v_r),
    .win       (win_r),
    .win_meta  (conv_meta_r),
    .res_valid (res_v),
    .res       (res),
    .busy      (conv_busy)
  );

  // Result queue; it decouples the output handshake from the pipeline.
  out_item_t      fifo_mem [DEPTH];
  logic [FA-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FA:0]    fifo_cnt_r;
  logic           fifo_push, fifo_pop;
  logic [OCC_W-1:0] occ;

  assign fifo_push = res_v;
  assign fifo_pop  = out_valid && out_ready;
  assign out_valid = (fifo_cnt_r != '0);
  assign out_data  = fifo_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_r <= wr_ptr_r + FA'(1);
      end
      if (fifo_pop) begin
        rd_ptr_r <= rd_ptr_r + FA'(1);
      end
      case ({fifo_push, fifo_pop})
        2'b10:   fifo_cnt_r <= fifo_cnt_r + (FA+1)'(1);
        2'b01:   fifo_cnt_r <= fifo_cnt_r - (FA+1)'(1);
        default: fifo_cnt_r <= fifo_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

  // Accept only while every result already on its way has a queue slot.
  always_comb begin
    occ = OCC_W'(fifo_cnt_r) + OCC_W'(s1_v_r && s1_emit_r) + OCC_W'(conv_v_r);
    for (int i = 0; i < CONV_STAGES; i++) begin
      occ = occ + OCC_W'(conv_busy[i]);
    end
  end

  assign in_ready = (occ < OCC_W'(DEPTH));

  // Checks on the queue credit scheme, forwarding and frame restarts.
  `GS5_ASSERT_SAME(a_fifo_no_overflow, clk, rst_n, fifo_push && !fifo_pop,
                   fifo_cnt_r < (FA+1)'(DEPTH), "result queue overflow")
  `GS5_ASSERT_SAME(a_occ_bound, clk, rst_n, 1'b1, occ <= OCC_W'(DEPTH),
                   "results in flight exceed queue depth")
  `GS5_ASSERT_SAME(a_fwd_has_item, clk, rst_n, fwd_v_r, s1_v_r,
                   "forwarding without an item in the read stage")
  `GS5_ASSERT_NEXT(a_start_col0, clk, rst_n, in_acc && in_data.frame_start, s1_x_r == '0,
                   "frame start not placed at column zero")

endmodule

>>> tb/sv/tb_gaussian_5x5_smoothing_unit.sv
// Self-checking testbench for the 5x5 Gaussian smoothing unit: a directed frame, then random
// frames under changing geometry, checked against a behavioral blur of the pixel stream.
// Depends on gs5_pkg and the gaussian_5x5_smoothing_unit RTL.
`timescale 1ns / 100ps

module tb_gaussian_5x5_smoothing_unit;
  import gs5_pkg::*;

  localparam int RAND_ITEMS  = 1050;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 16;

  // One row of the directed stimulus; want holds a typed-in result where typed is set.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             start;
    logic             typed;
    out_item_t        want;
  } dir_row_t;

  localparam out_item_t NO_RES = '0;
  // All 255 except the four corners, each of weight 1: 255 * 326 / 330 truncates to 251.
  localparam out_item_t CORNER_RES =
    '{smoothed: 8'd251, center_x: 11'd2, center_y: 12'd2, frame_last: 1'b1};
  localparam dir_row_t PX_FULL = '{8'd255, 1'b0, 1'b0, NO_RES};
  localparam dir_row_t PX_DARK = '{8'd0, 1'b0, 1'b0, NO_RES};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Behavioral copy of the block: registers, line stores, window and raster position.
  logic [LINE_WIDTH_W-1:0]   lw_reg;
  logic [FRAME_HEIGHT_W-1:0] fh_reg;
  logic [PIX_W-1:0]          line_mem [NLINES][MAX_WIDTH_DEF];
  logic [PIX_W-1:0]          win [KSIZE][KSIZE];
  int                        col_pos;
  int                        row_pos;

  out_item_t blur_q [$];
  int        errors;
  int        cycles;
  int        rand_sent;
  int        burst_left;
  int        gap_max;
  int        rx_mode;
  int        rx_left;

  // A 5x5 frame whose only window covers the whole frame; width and height are written
  // below the minimum, so both clamp up to 5.
  dir_row_t corner_tbl [25] = '{
    '{8'd0, 1'b1, 1'b0, NO_RES}, PX_FULL, PX_FULL, PX_FULL, PX_DARK,
    PX_FULL, PX_FULL, PX_FULL, PX_FULL, PX_FULL,
    PX_FULL, PX_FULL, PX_FULL, PX_FULL, PX_FULL,
    PX_FULL, PX_FULL, PX_FULL, PX_FULL, PX_FULL,
    PX_DARK, PX_FULL, PX_FULL, PX_FULL, '{8'd0, 1'b0, 1'b1, CORNER_RES}
  };

  gaussian_5x5_smoothing_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Out-of-range geometry is pulled into [5, hi].
  function automatic int eff_dim(input int v, input int hi);
    if (v < KSIZE) return KSIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mask weight from the distance to the window center along each axis.
  function automatic int gauss_weight(input int r, input int c);
    int dr;
    int dc;
    int lo;
    int hi;
    dr = (r > 2) ? r - 2 : 2 - r;
    dc = (c > 2) ? c - 2 : 2 - c;
    lo = (dr < dc) ? dr : dc;
    hi = (dr < dc) ? dc : dr;
    if (hi == 0) return W_CENTER;
    if (hi == 1) return (lo == 0) ? W_INAXIS : W_INDIAG;
    if (lo == 0) return W_MIDRIM;
    return (lo == 1) ? W_EDGE : W_CORNER;
  endfunction

  // Places one pixel in the raster and returns 1 with the smoothed result when the
  // window is full.
  function automatic bit blur_pixel(input in_item_t it, output out_item_t res);
    int w;
    int h;
    int x;
    int y;
    int acc;
    logic [PIX_W-1:0] column_px [KSIZE];
    w = eff_dim(int'(lw_reg), MAX_WIDTH_DEF);
    h = eff_dim(int'(fh_reg), MAX_HEIGHT_DEF);
    res = '0;
    if (it.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    // The position may lie past a geometry written since the last pixel.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    x = col_pos;
    y = row_pos;

    // The incoming column is the four stored rows above plus the new pixel.
    for (int r = 0; r < NLINES; r++) column_px[r] = line_mem[r][x];
    column_px[NLINES] = it.pixel;
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE - 1; c++) win[r][c] = win[r][c+1];
      win[r][KSIZE-1] = column_px[r];
    end
    for (int r = 0; r < NLINES - 1; r++) line_mem[r][x] = column_px[r+1];
    line_mem[NLINES-1][x] = it.pixel;

    col_pos = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= h) row_pos = 0;
    end

    if (x < KSIZE - 1 || y < KSIZE - 1) return 1'b0;
    acc = 0;
    for (int r = 0; r < KSIZE; r++)
      for (int c = 0; c < KSIZE; c++) acc += int'(win[r][c]) * gauss_weight(r, c);
    acc = acc / DIVISOR_DEF;
    if (acc > 255) acc = 255;
    res.smoothed   = PIX_W'(acc);
    res.center_x   = CX_W'(x - 2);
    res.center_y   = CY_W'(y - 2);
    res.frame_last = (x == w - 1 && y == h - 1);
    return 1'b1;
  endfunction

  // APB write followed by a read back of the same register; starts and ends at a falling edge.
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] want;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CFG_ADDR_W'(4 * int'(idx));
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    if (idx == REG_LINE_WIDTH) begin
      lw_reg = val[LINE_WIDTH_W-1:0];
      want   = CFG_DATA_W'(lw_reg);
    end else begin
      fh_reg = val[FRAME_HEIGHT_W-1:0];
      want   = CFG_DATA_W'(fh_reg);
    end
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (cfg_prdata !== want) begin
      errors++;
      $display("%0t: register %s read back: expected %0d, actual %0d",
               $time, idx.name(), want, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Presents one pixel beat at a falling edge and holds it until accepted.
  task automatic send_pixel(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t res;
    bit has_res;
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    has_res = blur_pixel(it, res);
    if (typed) blur_q.push_back(want);
    else if (has_res) blur_q.push_back(res);
    @(negedge clk);
  endtask

  // Drops valid, waits for every pending result, then lets the pipeline run empty.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (blur_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Sends a run of random pixels in bursts; fill selects the kind of content.
  task automatic send_run(input int count, input bit start_first, input int fill);
    in_item_t  it;
    out_item_t none;
    int        cval;
    int        gap;
    none = '0;
    cval = $urandom_range(0, 255);
    for (int i = 0; i < count; i++) begin
      case (fill)
        0: it.pixel = PIX_W'($urandom_range(0, 255));
        1: it.pixel = $urandom_range(0, 1) ? PIX_MAX : '0;
        2: begin
          gap = $urandom_range(0, 3);
          it.pixel = (gap == 0) ? '0 : (gap == 1) ? PIX_MAX : PIX_W'($urandom_range(0, 255));
        end
        3: it.pixel = PIX_W'(cval);
        default: it.pixel = PIX_W'(i * 7 + cval);
      endcase
      // A stray frame start now and then restarts the raster mid-frame.
      it.frame_start = (i == 0) ? start_first : ($urandom_range(0, 99) < 3);
      send_pixel(it, 1'b0, none);
      rand_sent++;
      if (gap_max != 0) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap = $urandom_range(1, gap_max);
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end else begin
          burst_left--;
        end
      end
    end
  endtask

  // Result receiver: stall pattern switches between always ready, light, half and heavy stalls.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(5, 60);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready = 1'b1;
      1: out_ready = ($urandom_range(0, 3) != 0);
      2: out_ready = $urandom_range(0, 1);
      default: out_ready = ($urandom_range(0, 7) == 0);
    endcase
  end

  // Each accepted result beat is checked against the oldest expected one.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (blur_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %0d at (%0d,%0d) last %0d",
                 $time, out_data.smoothed, out_data.center_x, out_data.center_y,
                 out_data.frame_last);
      end else begin
        want = blur_q.pop_front();
        if (out_data.smoothed !== want.smoothed || out_data.center_x !== want.center_x ||
            out_data.center_y !== want.center_y || out_data.frame_last !== want.frame_last) begin
          errors++;
          $display("%0t: expected %0d at (%0d,%0d) last %0d, actual %0d at (%0d,%0d) last %0d",
                   $time, want.smoothed, want.center_x, want.center_y, want.frame_last,
                   out_data.smoothed, out_data.center_x, out_data.center_y,
                   out_data.frame_last);
        end
      end
    end
  end

  // Stimulus: reset, the directed frame, then random phases of geometry and pixels.
  initial begin
    int                    w_old;
    int                    w_new;
    int                    h_new;
    int                    n;
    int                    sel;
    int                    pick;
    int                    fill;
    bit                    start_first;
    bit                    was_wide;
    bit                    after_wide;
    logic [CFG_DATA_W-1:0] val;

    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    errors      = 0;
    cycles      = 0;
    rand_sent   = 0;
    burst_left  = 0;
    gap_max     = 0;
    rx_mode     = 0;
    rx_left     = 0;
    after_wide  = 1'b0;
    lw_reg      = LINE_WIDTH_W'(LINE_WIDTH_RST);
    fh_reg      = FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
    col_pos     = 0;
    row_pos     = 0;
    for (int r = 0; r < NLINES; r++)
      for (int c = 0; c < MAX_WIDTH_DEF; c++) line_mem[r][c] = '0;
    for (int r = 0; r < KSIZE; r++)
      for (int c = 0; c < KSIZE; c++) win[r][c] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed frame with both dimensions clamped up from below.
    cfg_write(REG_LINE_WIDTH, 32'd3);
    cfg_write(REG_FRAME_HEIGHT, 32'd0);
    foreach (corner_tbl[i])
      send_pixel(in_item_t'{pixel: corner_tbl[i].pixel, frame_start: corner_tbl[i].start},
                 corner_tbl[i].typed, corner_tbl[i].want);

    // Random phases; each begins with the block drained.
    while (rand_sent < RAND_ITEMS) begin
      wait_idle();
      w_old = eff_dim(int'(lw_reg), MAX_WIDTH_DEF);
      was_wide = after_wide;
      if (was_wide || $urandom_range(0, 3) != 0) begin
        sel = was_wide ? 0 : $urandom_range(0, 2);
        if (sel != 2) begin
          // After a wide phase the width always shrinks to between 5 and 12.
          pick = $urandom_range(0, 99);
          if (was_wide || pick >= 16) val = $urandom_range(5, 12);
          else if (pick < 10) val = $urandom_range(0, 4);
          else if (pick < 13) val = MAX_WIDTH_DEF;
          else val = $urandom_range(MAX_WIDTH_DEF + 1, 4095);
          cfg_write(REG_LINE_WIDTH, val);
        end
        if (sel != 1) begin
          pick = $urandom_range(0, 99);
          if (pick < 10) val = $urandom_range(0, 4);
          else if (pick < 13) val = MAX_HEIGHT_DEF;
          else if (pick < 16) val = $urandom_range(MAX_HEIGHT_DEF + 1, 8191);
          else if (pick < 30) val = $urandom_range(9, 20);
          else val = $urandom_range(5, 8);
          cfg_write(REG_FRAME_HEIGHT, val);
        end
      end
      w_new = eff_dim(int'(lw_reg), MAX_WIDTH_DEF);
      h_new = eff_dim(int'(fh_reg), MAX_HEIGHT_DEF);
      after_wide = (w_new > 64);

      // A wider row mid-frame would reach columns the line stores never held, so the
      // raster restarts; a narrower one may continue and wrap the column.
      start_first = (w_new > w_old && (col_pos != 0 || row_pos != 0)) ||
                    (!was_wide && $urandom_range(0, 9) < 6);

      // Wide rows only get a short run; small frames run whole once or twice, plus part of the next.
      if (w_new > 64) n = $urandom_range(20, 60);
      else if (h_new > 20) n = w_new * $urandom_range(6, 14) + $urandom_range(0, w_new - 1);
      else n = $urandom_range(1, 2) * w_new * h_new + $urandom_range(0, 2 * w_new);

      pick = $urandom_range(0, 3);
      gap_max = pick * 3;
      burst_left = 0;
      fill = $urandom_range(0, 4);
      send_run(n, start_first, fill);
    end

    // Drain and let the pipeline settle before the verdict.
    in_valid = 1'b0;
    while (blur_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
